/* rtl/bipp_pkg.sv */
// Shared constants and character classes for the bracketed integer pair parser.
// No dependencies; imported by the parser top level, its checker and the test bench.
`timescale 1ns / 1ps

package bipp_pkg;

   localparam int NUM_BITS   = 64;   // accumulator width, 32 to 64
   localparam int OUT_BITS   = 64;   // width of each reported integer
   localparam int CHAR_BITS  = 8;
   localparam int RSP_DATA_W = 2 * OUT_BITS;

   localparam logic [NUM_BITS-1:0] POS_LIM = {1'b0, {(NUM_BITS-1){1'b1}}};

   localparam logic [CHAR_BITS-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_LF      = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_COMMA   = 8'h2C;
   localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_OPEN    = 8'h5B;
   localparam logic [CHAR_BITS-1:0] CH_CLOSE   = 8'h5D;

   function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // blanks skipped ahead of a number: space, tab, LF, VT, FF, CR
   function automatic logic is_lead_blank(input logic [CHAR_BITS-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // blanks allowed after a number
   function automatic logic is_gap_blank(input logic [CHAR_BITS-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

endpackage

/* rtl/bracketed_integer_pair_parser.sv */
// Streaming parser for texts of the form "[secs, usecs]", one character per transfer.
// Depends on bipp_pkg for widths, character codes and character classes.
//
//   channel | dir | tdata                                   | tuser
//   req     | in  | [7:0] char_code                         | -
//   rsp     | out | [63:0] seconds_value, [127:64] micros    | [0] parse_ok
//
// One character per cycle while rsp is not stalled: a character is registered in the
// input register, then decoded and folded into the accumulator (multiply by ten via
// shift-add, one wide add and compare) as it leaves that register, loading the result register.
// Reset is synchronous; it arms the parser to expect an opening bracket.
// While a result waits on rsp_tready, the input register holds and req_tready
// drops once it is full; characters that give no result still need that slot.
`timescale 1ns / 1ps

module bracketed_integer_pair_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bipp_pkg::CHAR_BITS-1:0]    req_tdata,   // [7:0] char_code
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bipp_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [63:0] seconds_value,
                                                          // [127:64] micros_value
   output logic                              rsp_tuser    // [0] parse_ok
);
   import bipp_pkg::*;

   typedef enum logic [3:0] {
      PH_OPEN, PH_PRE1, PH_SIGN1, PH_DIG1, PH_GAP1,
      PH_PRE2, PH_SIGN2, PH_DIG2, PH_GAP2, PH_ABSORB
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic                      in_valid_ff, in_valid_in;
   logic [CHAR_BITS-1:0]      in_char_ff, in_char_in;
   logic                      minus_ff, minus_in;
   logic [NUM_BITS-1:0]       mag_ff, mag_in;
   logic                      ovf_ff, ovf_in;
   logic [OUT_BITS-1:0]       first_ff, first_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_ok_ff, rsp_ok_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                      advance;
   logic                      ok, fail;
   logic [CHAR_BITS-1:0]      c;
   logic [NUM_BITS+3:0]       times_ten, lim_ext;
   logic                      digit_over;
   logic [NUM_BITS-1:0]       lim_sel, mag_sel, val_n;
   logic [OUT_BITS-1:0]       num_value;

   assign c       = in_char_ff;
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);

   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

   // mag * 10 + digit against the limit for the current sign
   assign times_ten  = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0}
                       + (NUM_BITS+4)'(c[3:0]);
   assign lim_ext    = (NUM_BITS+4)'(POS_LIM) + (NUM_BITS+4)'(minus_ff);
   assign digit_over = times_ten > lim_ext;

   // saturated signed value of the number in progress
   assign lim_sel   = POS_LIM + NUM_BITS'(minus_ff);
   assign mag_sel   = ovf_ff ? lim_sel : mag_ff;
   assign val_n     = minus_ff ? (NUM_BITS'(0) - mag_sel) : mag_sel;
   assign num_value = OUT_BITS'($signed(val_n));

   always_comb begin
      phase_in     = phase_ff;
      minus_in     = minus_ff;
      mag_in       = mag_ff;
      ovf_in       = ovf_ff;
      first_in     = first_ff;
      ok           = 1'b0;
      fail         = 1'b0;
      in_valid_in  = in_valid_ff;
      in_char_in   = in_char_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;

      if (advance) begin
         in_valid_in = 1'b0;
         if (phase_ff == PH_ABSORB) begin
            if (c == CH_NUL) begin
               phase_in = PH_OPEN;
            end
         end else if (c == CH_NUL) begin
            fail = 1'b1;
         end else begin
            case (phase_ff)
               PH_OPEN: begin
                  if (c == CH_OPEN) begin
                     phase_in = PH_PRE1;
                     minus_in = 1'b0;
                     mag_in   = '0;
                     ovf_in   = 1'b0;
                  end else begin
                     fail = 1'b1;
                  end
               end
               PH_PRE1, PH_PRE2: begin
                  if (is_lead_blank(c)) begin
                     phase_in = phase_ff;
                  end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                     minus_in = (c == CH_MINUS);
                     phase_in = (phase_ff == PH_PRE1) ? PH_SIGN1 : PH_SIGN2;
                  end else if (is_digit(c)) begin
                     if (!ovf_ff) begin
                        if (digit_over) ovf_in = 1'b1;
                        else            mag_in = times_ten[NUM_BITS-1:0];
                     end
                     phase_in = (phase_ff == PH_PRE1) ? PH_DIG1 : PH_DIG2;
                  end else begin
                     fail = 1'b1;
                  end
               end
               PH_SIGN1, PH_SIGN2: begin
                  if (is_digit(c)) begin
                     if (!ovf_ff) begin
                        if (digit_over) ovf_in = 1'b1;
                        else            mag_in = times_ten[NUM_BITS-1:0];
                     end
                     phase_in = (phase_ff == PH_SIGN1) ? PH_DIG1 : PH_DIG2;
                  end else begin
                     fail = 1'b1;
                  end
               end
               PH_DIG1: begin
                  if (is_digit(c)) begin
                     if (!ovf_ff) begin
                        if (digit_over) ovf_in = 1'b1;
                        else            mag_in = times_ten[NUM_BITS-1:0];
                     end
                  end else begin
                     first_in = num_value;
                     if (is_gap_blank(c)) begin
                        phase_in = PH_GAP1;
                     end else if (c == CH_COMMA) begin
                        phase_in = PH_PRE2;
                        minus_in = 1'b0;
                        mag_in   = '0;
                        ovf_in   = 1'b0;
                     end else begin
                        fail = 1'b1;
                     end
                  end
               end
               PH_GAP1: begin
                  if (is_gap_blank(c)) begin
                     phase_in = PH_GAP1;
                  end else if (c == CH_COMMA) begin
                     phase_in = PH_PRE2;
                     minus_in = 1'b0;
                     mag_in   = '0;
                     ovf_in   = 1'b0;
                  end else begin
                     fail = 1'b1;
                  end
               end
               PH_DIG2: begin
                  if (is_digit(c)) begin
                     if (!ovf_ff) begin
                        if (digit_over) ovf_in = 1'b1;
                        else            mag_in = times_ten[NUM_BITS-1:0];
                     end
                  end else if (is_gap_blank(c)) begin
                     phase_in = PH_GAP2;
                  end else if (c == CH_CLOSE) begin
                     ok = 1'b1;
                  end else begin
                     fail = 1'b1;
                  end
               end
               PH_GAP2: begin
                  if (is_gap_blank(c)) begin
                     phase_in = PH_GAP2;
                  end else if (c == CH_CLOSE) begin
                     ok = 1'b1;
                  end else begin
                     fail = 1'b1;
                  end
               end
               default: begin
                  fail = 1'b1;
               end
            endcase
         end

         if (ok || fail) begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = ok;
            rsp_data_in  = ok ? {num_value, first_ff} : '0;
            // end of text rearms at once; otherwise drop characters until it
            phase_in     = (c == CH_NUL) ? PH_OPEN : PH_ABSORB;
         end
      end

      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPEN;
         in_valid_ff  <= 1'b0;
         minus_ff     <= 1'b0;
         mag_ff       <= '0;
         ovf_ff       <= 1'b0;
         first_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         in_valid_ff  <= in_valid_in;
         minus_ff     <= minus_in;
         mag_ff       <= mag_in;
         ovf_ff       <= ovf_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_char_ff  <= in_char_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/bipp_checker.sv */
// Port-level checks for the bracketed integer pair parser, bound to its top level.
// Depends on bipp_pkg for the result width.
`timescale 1ns / 1ps

module bipp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bipp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser
);
   import bipp_pkg::*;

   // no result shows in the cycle right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a failed parse reports both integers as zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("failure result carries nonzero values");

   // a stalled result holds until transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind bracketed_integer_pair_parser bipp_checker u_bipp_checker (.*);

/* tb/bracketed_integer_pair_parser_test.sv */
// Self-checking bench for bracketed_integer_pair_parser: streams "[secs, usecs]" texts
// into the parser and checks each reported outcome against a local parse predictor.
// Depends on bipp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module bracketed_integer_pair_parser_test;

   import bipp_pkg::*;

   localparam int NB         = NUM_BITS;
   localparam int RADIX      = 10;
   localparam int IDLE_LIMIT = 4000;   // cycles with no transfer on either side
   localparam int HOLD_LEN   = 300;    // long receiver hold-off
   localparam int TARGET     = 425;    // directed plus random characters

   typedef enum logic [3:0] {
      WANT_OPEN, LEAD1, SIGN1, DIGITS1, GAP1, LEAD2, SIGN2, DIGITS2, GAP2, DRAIN
   } parse_phase_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] secs;
      logic [63:0] usecs;
   } parse_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CHAR_BITS-1:0]  req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   bracketed_integer_pair_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor state
   parse_phase_type   phase = WANT_OPEN;
   logic              neg = 1'b0;
   logic [63:0]       acc = '0;
   logic              ovf = 1'b0;
   logic [63:0]       secs_held = '0;

   logic [7:0]        pending_chars[$];
   logic [7:0]        text_buf[$];
   parse_outcome_type expected_outcomes[$];

   logic           char_taken = 1'b0;
   logic           outcome_taken = 1'b0;
   int unsigned    chars_in = 0;
   int unsigned    mismatches = 0;
   int unsigned    idle_cycles = 0;
   int unsigned    send_gap = 0;
   int unsigned    stall_left = 0;
   int unsigned    hold_left = 0;
   logic           hold_done = 1'b0;

   function automatic logic digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // space plus tab through CR (includes VT and FF)
   function automatic logic lead_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic gap_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   task automatic clear_number();
      neg = 1'b0;
      acc = '0;
      ovf = 1'b0;
   endtask

   // stop growing once the magnitude passes the limit for this sign
   task automatic fold_digit(input logic [7:0] c);
      logic [63:0] lim;
      logic [63:0] d;
      lim = 64'(POS_LIM) + (neg ? 64'd1 : 64'd0);
      d   = 64'(c - CH_ZERO);
      if (!ovf) begin
         if (acc > (lim - d) / RADIX)
            ovf = 1'b1;
         else
            acc = acc * RADIX + d;
      end
   endtask

   function automatic logic [63:0] number_now();
      logic [63:0]          lim;
      logic [63:0]          mag;
      logic [NB-1:0]        narrow;
      logic signed [63:0]   wide;
      lim = 64'(POS_LIM);
      if (neg)
         mag = 64'd0 - (ovf ? lim + 64'd1 : acc);
      else
         mag = ovf ? lim : acc;
      narrow = mag[NB-1:0];
      wide   = $signed(narrow);
      return wide;
   endfunction

   task automatic step_parser(input logic [7:0] c, output logic fired,
                              output parse_outcome_type res);
      logic ok;
      logic bad;
      ok    = 1'b0;
      bad   = 1'b0;
      fired = 1'b0;
      res   = '0;
      if (phase == DRAIN) begin
         if (c == CH_NUL)
            phase = WANT_OPEN;
         return;
      end
      if (c == CH_NUL)
         bad = 1'b1;
      else begin
         case (phase)
            WANT_OPEN: begin
               if (c == CH_OPEN) begin
                  phase = LEAD1;
                  clear_number();
               end else
                  bad = 1'b1;
            end
            LEAD1, LEAD2: begin
               if (!lead_blank(c)) begin
                  if (c == CH_PLUS || c == CH_MINUS) begin
                     neg   = (c == CH_MINUS);
                     phase = (phase == LEAD1) ? SIGN1 : SIGN2;
                  end else if (digit(c)) begin
                     fold_digit(c);
                     phase = (phase == LEAD1) ? DIGITS1 : DIGITS2;
                  end else
                     bad = 1'b1;
               end
            end
            SIGN1, SIGN2: begin
               if (digit(c)) begin
                  fold_digit(c);
                  phase = (phase == SIGN1) ? DIGITS1 : DIGITS2;
               end else
                  bad = 1'b1;
            end
            DIGITS1: begin
               if (digit(c))
                  fold_digit(c);
               else begin
                  secs_held = number_now();
                  if (gap_blank(c))
                     phase = GAP1;
                  else if (c == CH_COMMA) begin
                     phase = LEAD2;
                     clear_number();
                  end else
                     bad = 1'b1;
               end
            end
            GAP1: begin
               if (!gap_blank(c)) begin
                  if (c == CH_COMMA) begin
                     phase = LEAD2;
                     clear_number();
                  end else
                     bad = 1'b1;
               end
            end
            DIGITS2: begin
               if (digit(c))
                  fold_digit(c);
               else if (gap_blank(c))
                  phase = GAP2;
               else if (c == CH_CLOSE)
                  ok = 1'b1;
               else
                  bad = 1'b1;
            end
            GAP2: begin
               if (!gap_blank(c)) begin
                  if (c == CH_CLOSE)
                     ok = 1'b1;
                  else
                     bad = 1'b1;
               end
            end
            default: bad = 1'b1;
         endcase
      end
      if (ok || bad) begin
         fired     = 1'b1;
         res.ok    = ok;
         res.secs  = ok ? secs_held : 64'd0;
         res.usecs = ok ? number_now() : 64'd0;
         phase     = (c == CH_NUL) ? WANT_OPEN : DRAIN;
      end
   endtask

   // ---------------------------------------------------------------- idle pattern
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if ((chars_in / 64) % 4 == 1)
         return 0;   // stretch with no idling
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(3, 1);
      if (roll < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // ---------------------------------------------------------------- sender
   always @(negedge clock) begin
      if (reset)
         req_tvalid <= 1'b0;
      else if (!req_tvalid || char_taken) begin
         if (send_gap != 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_chars.size() != 0) begin
            req_tdata  <= pending_chars.pop_front();
            req_tvalid <= 1'b1;
            send_gap   <= pick_gap();
         end else
            req_tvalid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- receiver
   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && chars_in >= 120) begin
         // long hold-off so the parser backs up and stalls its input
         hold_done  <= 1'b1;
         hold_left  <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (outcome_taken || $urandom_range(7) == 0)
            stall_left <= pick_gap();
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      parse_outcome_type want;
      parse_outcome_type got;
      parse_outcome_type res;
      logic              fired;
      char_taken    <= req_tvalid && req_tready;
      outcome_taken <= rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.ok    = rsp_tuser;
            got.secs  = rsp_tdata[OUT_BITS-1:0];
            got.usecs = rsp_tdata[2*OUT_BITS-1:OUT_BITS];
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: ok=%0b secs=%0d usecs=%0d",
                           got.ok, $signed(got.secs), $signed(got.usecs));
            end else begin
               want = expected_outcomes.pop_front();
               if (got.ok !== want.ok || got.secs !== want.secs ||
                   got.usecs !== want.usecs) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected ok=%0b %0d %0d, got ok=%0b %0d %0d",
                              want.ok, $signed(want.secs), $signed(want.usecs),
                              got.ok, $signed(got.secs), $signed(got.usecs));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            chars_in <= chars_in + 1;
            step_parser(req_tdata, fired, res);
            if (fired)
               expected_outcomes.push_back(res);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAIL bracketed_integer_pair_parser");
            $finish;
         end else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         pending_chars.push_back(8'(s[i]));
   endtask

   task automatic buf_text(input string s);
      for (int i = 0; i < s.len(); i++)
         text_buf.push_back(8'(s[i]));
   endtask

   task automatic buf_blanks(input logic lead);
      logic [7:0] lead_set[6];
      logic [7:0] gap_set[4];
      int unsigned n;
      lead_set = '{CH_SPACE, CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR};
      gap_set  = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
      n = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
      repeat (n) begin
         if (lead)
            text_buf.push_back(lead_set[$urandom_range(5)]);
         else
            text_buf.push_back(gap_set[$urandom_range(3)]);
      end
   endtask

   task automatic buf_number();
      string       edge_vals[5];
      int unsigned roll;
      int unsigned len;
      edge_vals = '{"9223372036854775807", "9223372036854775808", "99999999999999999999",
                    "0000000000000000000001", "0"};
      case ($urandom_range(2))
         0: text_buf.push_back(CH_MINUS);
         1: text_buf.push_back(CH_PLUS);
         default: ;
      endcase
      roll = $urandom_range(99);
      if (roll < 12)
         buf_text(edge_vals[$urandom_range(4)]);
      else begin
         len = (roll < 85) ? $urandom_range(4, 1) : $urandom_range(24, 5);
         repeat (len)
            text_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
      end
   endtask

   task automatic add_random_text();
      int unsigned kind;
      int unsigned pos;
      text_buf.delete();
      kind = $urandom_range(99);
      if (kind < 10) begin
         // noise
         repeat ($urandom_range(6, 1))
            text_buf.push_back(8'($urandom_range(255, 1)));
      end else begin
         text_buf.push_back(CH_OPEN);
         buf_blanks(1'b1);
         buf_number();
         buf_blanks(1'b0);
         text_buf.push_back(CH_COMMA);
         buf_blanks(1'b1);
         buf_number();
         buf_blanks(1'b0);
         text_buf.push_back(CH_CLOSE);
         if ($urandom_range(4) == 0)
            repeat ($urandom_range(4, 1))
               text_buf.push_back(8'($urandom_range(255, 1)));
         if (kind >= 75) begin
            // break the sequence: corrupt one character or cut it short
            pos = $urandom_range(text_buf.size() - 1);
            if ($urandom_range(1) == 0)
               text_buf[pos] = 8'($urandom_range(255));
            else
               text_buf = text_buf[0:pos];
         end
      end
      foreach (text_buf[i])
         pending_chars.push_back(text_buf[i]);
      if ($urandom_range(19) != 0)
         pending_chars.push_back(CH_NUL);
   endtask

   initial begin
      // empty text
      pending_chars.push_back(CH_NUL);
      // sign with no digits, then characters absorbed until the terminator
      add_text("[-,x");
      pending_chars.push_back(CH_NUL);
      // VT, FF and LF as lead blanks, explicit signs, gap before the comma
      add_text("[\v\f+7 ,\n-0\r]");
      pending_chars.push_back(CH_NUL);
      // missing first number
      add_text("[,");
      pending_chars.push_back(CH_NUL);
      // end of text before the outcome
      add_text("[5");
      pending_chars.push_back(CH_NUL);
      // top byte value where a bracket belongs
      pending_chars.push_back(8'hFF);
      pending_chars.push_back(CH_NUL);

      while (pending_chars.size() < TARGET)
         add_random_text();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (pending_chars.size() == 0 && !req_tvalid);
      while (expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0)
         $display("PASS bracketed_integer_pair_parser");
      else
         $display("FAIL bracketed_integer_pair_parser");
      $finish;
   end

endmodule

/* sim.f */
rtl/bipp_pkg.sv
rtl/bracketed_integer_pair_parser.sv
rtl/bipp_checker.sv
tb/bracketed_integer_pair_parser_test.sv
